[design/fractional_period_timer_bank_core_macros.svh]
// assertion macros for the fractional period timer bank
`ifndef FRACTIONAL_PERIOD_TIMER_BANK_CORE_MACROS_SVH
`define FRACTIONAL_PERIOD_TIMER_BANK_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define FPTB_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define FPTB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define FPTB_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define FPTB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[design/fptb_pkg.sv]
// shared types and constants of the fractional period timer bank
`timescale 1ns / 1ps

package fptb_pkg;

	localparam int NUM_TIMERS = 16;
	localparam int FRAC_BITS  = 16;

	localparam int SLOT_W   = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int CNT_W    = $clog2(NUM_TIMERS + 1);
	localparam int ID_W     = 32;
	localparam int WHOLE_W  = 16;
	localparam int FRAMES_W = WHOLE_W + 1;
	localparam int ACC_W    = FRAC_BITS + 1;
	localparam int MODE_W   = 2;
	localparam int KIND_W   = 3;

	// 1.0 in the accumulator format
	localparam logic [ACC_W-1:0] ONE_FIX = {1'b1, {FRAC_BITS{1'b0}}};

	localparam logic [MODE_W-1:0] MODE_TICK   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ADD    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CANCEL = 2'd2;

	localparam logic [KIND_W-1:0] K_ADDED     = 3'd0;
	localparam logic [KIND_W-1:0] K_FULL      = 3'd1;
	localparam logic [KIND_W-1:0] K_EXPIRED   = 3'd2;
	localparam logic [KIND_W-1:0] K_NONE      = 3'd3;
	localparam logic [KIND_W-1:0] K_CANCELLED = 3'd4;
	localparam logic [KIND_W-1:0] K_MISS      = 3'd5;

	typedef struct packed {
		logic [ID_W-1:0]      id;
		logic [FRAMES_W-1:0]  frames;
		logic [WHOLE_W-1:0]   reload_whole;
		logic [ACC_W-1:0]     accum;
		logic [FRAC_BITS-1:0] reload_frac;
		logic                 recurring;
	} entry_t;

	typedef struct packed {
		logic hit;
		logic free;
	} upd_stat_t;

	typedef struct packed {
		logic ins;
		logic pop;
	} hq_ctrl_t;

endpackage

[design/fractional_period_timer_bank_core.sv]
// top level of the fractional period timer bank
//
// channel  dir  handshake          tdata / tuser
// s_*      in   s_tvalid/s_tready  request: period, fraction, repeat, target; tuser mode
// m_*      out  m_tvalid/m_tready  result: timer id; tuser kind; tlast closes request
//
// add writes a free slot, then answers; cancel walks the slots until the first
// match or the end; tick makes the one-slot-per-cycle walk over the slot memory
// read port, then emits its results. one request is in work at a time; a new
// request is taken while the last result still sits in the output register.
// reset clears the valid bits, the id counter and the control state; the slot
// memory needs no clearing pass.
`timescale 1ns / 1ps
`include "fractional_period_timer_bank_core_macros.svh"

module fractional_period_timer_bank_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [15:0] period_whole, [31:16] period_frac, [32] repeat_flag, [64:33] target_id
	input  logic [71:0] s_tdata,
	// [1:0] mode
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [31:0] timer_id
	output logic [31:0] m_tdata,
	// [2:0] kind
	output logic [2:0]  m_tuser,
	output logic        m_tlast
);

	import fptb_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_ADD  = 3'd1;
	localparam logic [2:0] ST_CAN  = 3'd2;
	localparam logic [2:0] ST_TICK = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;
	localparam logic [2:0] ST_RESP = 3'd5;

	logic [2:0]            state_q;
	logic [NUM_TIMERS-1:0] valid_q;
	logic [ID_W-1:0]       next_id_q;
	logic [CNT_W-1:0]      idx_q;
	logic [SLOT_W-1:0]     addr_s1;
	logic                  pend_s1;

	logic [WHOLE_W-1:0]    whole_q;
	logic [FRAC_BITS-1:0]  frac_q;
	logic                  rep_q;
	logic [ID_W-1:0]       tgt_q;
	logic [KIND_W-1:0]     resp_kind_q;
	logic [ID_W-1:0]       resp_id_q;

	logic                  m_tvalid_q;
	logic [KIND_W-1:0]     kind_q;
	logic [ID_W-1:0]       id_q;
	logic                  last_q;

	logic                  s_acc;
	logic                  out_free;
	logic                  out_load;
	logic [KIND_W-1:0]     out_kind;
	logic [ID_W-1:0]       out_id;
	logic                  out_last;

	logic                  ram_we;
	logic [SLOT_W-1:0]     ram_waddr;
	entry_t                ram_wdata;
	logic                  ram_re;
	logic [$bits(entry_t)-1:0] ram_rdata;
	entry_t                rd_entry;
	entry_t                upd_entry;
	upd_stat_t             upd_stat;

	hq_ctrl_t              hq_ctrl;
	logic [ID_W-1:0]       hq_head;
	logic [CNT_W-1:0]      hq_count;

	logic                  any_free;
	logic [SLOT_W-1:0]     free_idx;
	logic [WHOLE_W-1:0]    whole_fix;
	logic                  walk_end;
	logic                  slot_live;
	logic                  can_hit;

	assign s_tready = state_q == ST_IDLE;
	assign s_acc    = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign rd_entry = entry_t'(ram_rdata);
	assign walk_end = (idx_q == CNT_W'(NUM_TIMERS)) && !pend_s1;
	assign slot_live = pend_s1 && valid_q[addr_s1];
	assign can_hit  = slot_live && (rd_entry.id == tgt_q);
	assign whole_fix = (whole_q == '0) ? WHOLE_W'(1) : whole_q;

	// lowest free slot
	always_comb begin
		any_free = 1'b0;
		free_idx = '0;
		for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				any_free = 1'b1;
				free_idx = SLOT_W'(i);
			end
		end
	end

	fptb_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(NUM_TIMERS)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (idx_q[SLOT_W-1:0]),
		.rdata (ram_rdata)
	);

	fptb_slot_upd u_upd (
		.cur  (rd_entry),
		.nxt  (upd_entry),
		.stat (upd_stat)
	);

	fptb_hit_queue u_hq (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (hq_ctrl),
		.ins_id  (rd_entry.id),
		.head_id (hq_head),
		.count   (hq_count)
	);

	always_comb begin
		ram_re    = ((state_q == ST_TICK) || (state_q == ST_CAN)) &&
			(idx_q != CNT_W'(NUM_TIMERS));
		ram_we    = 1'b0;
		ram_waddr = addr_s1;
		ram_wdata = upd_entry;
		hq_ctrl   = '0;
		out_load  = 1'b0;
		out_kind  = resp_kind_q;
		out_id    = resp_id_q;
		out_last  = 1'b1;
		unique case (state_q)
			ST_ADD: begin
				if (any_free) begin
					ram_we                 = 1'b1;
					ram_waddr              = free_idx;
					ram_wdata.id           = next_id_q;
					ram_wdata.frames       = FRAMES_W'(whole_fix);
					ram_wdata.reload_whole = whole_fix;
					ram_wdata.accum        = ACC_W'(frac_q);
					ram_wdata.reload_frac  = frac_q;
					ram_wdata.recurring    = rep_q;
				end
			end
			ST_TICK: begin
				if (slot_live) begin
					ram_we      = 1'b1;
					hq_ctrl.ins = upd_stat.hit;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					out_load = 1'b1;
					if (hq_count == '0) begin
						out_kind = K_NONE;
						out_id   = '0;
					end else begin
						out_kind    = K_EXPIRED;
						out_id      = hq_head;
						out_last    = hq_count == CNT_W'(1);
						hq_ctrl.pop = 1'b1;
					end
				end
			end
			ST_RESP: begin
				out_load = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			valid_q   <= '0;
			next_id_q <= '0;
			idx_q     <= '0;
			pend_s1   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					idx_q   <= '0;
					pend_s1 <= 1'b0;
					if (s_acc) begin
						unique case (s_tuser)
							MODE_TICK:   state_q <= ST_TICK;
							MODE_ADD:    state_q <= ST_ADD;
							MODE_CANCEL: state_q <= ST_CAN;
							default:     state_q <= ST_IDLE;
						endcase
					end
				end
				ST_ADD: begin
					if (any_free) begin
						valid_q[free_idx] <= 1'b1;
						next_id_q         <= next_id_q + ID_W'(1);
					end
					state_q <= ST_RESP;
				end
				ST_TICK, ST_CAN: begin
					pend_s1 <= ram_re;
					if (ram_re) begin
						idx_q <= idx_q + CNT_W'(1);
					end
					if (state_q == ST_TICK) begin
						if (slot_live && upd_stat.free) begin
							valid_q[addr_s1] <= 1'b0;
						end
						if (walk_end) begin
							state_q <= ST_EMIT;
						end
					end else if (can_hit) begin
						// first match is the lowest slot
						valid_q[addr_s1] <= 1'b0;
						state_q          <= ST_RESP;
					end else if (walk_end) begin
						state_q <= ST_RESP;
					end
				end
				ST_EMIT: begin
					if (out_load && out_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_RESP: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// request fields and single-result response
	always_ff @(posedge clk) begin
		if (s_acc) begin
			whole_q <= s_tdata[15:0];
			frac_q  <= s_tdata[31:16];
			rep_q   <= s_tdata[32];
			tgt_q   <= s_tdata[64:33];
		end
		if (ram_re) begin
			addr_s1 <= idx_q[SLOT_W-1:0];
		end
		unique case (state_q)
			ST_ADD: begin
				resp_kind_q <= any_free ? K_ADDED : K_FULL;
				resp_id_q   <= any_free ? next_id_q : '0;
			end
			ST_CAN: begin
				resp_kind_q <= can_hit ? K_CANCELLED : K_MISS;
				resp_id_q   <= tgt_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			kind_q <= out_kind;
			id_q   <= out_id;
			last_q <= out_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = id_q;
	assign m_tuser  = kind_q;
	assign m_tlast  = last_q;

	`FPTB_ASSERT_IMPLIES(a_ram_we_src, clk, arst_n, ram_we, (state_q == ST_ADD) || ((state_q == ST_TICK) && pend_s1))
	`FPTB_ASSERT_IMPLIES(a_hq_room, clk, arst_n, hq_ctrl.ins, hq_count != CNT_W'(NUM_TIMERS))
	`FPTB_ASSERT_NEXT(a_add_fills, clk, arst_n, (state_q == ST_ADD) && any_free, $countones(valid_q) == $countones($past(valid_q)) + 1)
	`FPTB_ASSERT_NEXT(a_id_hold, clk, arst_n, !((state_q == ST_ADD) && any_free), $stable(next_id_q))

endmodule

[design/fptb_ram.sv]
// generic simple dual port ram with registered read
`timescale 1ns / 1ps

module fptb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic                                        re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[design/fptb_slot_upd.sv]
// per-slot frame decrement and fractional reload
`timescale 1ns / 1ps

module fptb_slot_upd (
	input  fptb_pkg::entry_t    cur,
	output fptb_pkg::entry_t    nxt,
	output fptb_pkg::upd_stat_t stat
);

	import fptb_pkg::*;

	logic [FRAMES_W-1:0] dec;
	logic [WHOLE_W-1:0]  whole_fix;
	logic [ACC_W-1:0]    sum;
	logic                extra;

	always_comb begin
		dec       = cur.frames - FRAMES_W'(1);
		whole_fix = (cur.reload_whole == '0) ? WHOLE_W'(1) : cur.reload_whole;
		// accumulator never exceeds 1.0 before the add, so the sum fits
		sum       = cur.accum + ACC_W'(cur.reload_frac);
		extra     = sum > ONE_FIX;

		nxt         = cur;
		nxt.frames  = dec;
		stat.hit    = dec == '0;
		stat.free   = stat.hit && !cur.recurring;
		if (stat.hit && cur.recurring) begin
			nxt.accum  = extra ? sum - ONE_FIX : sum;
			nxt.frames = FRAMES_W'(whole_fix) + FRAMES_W'(extra);
		end
	end

endmodule

[design/fptb_hit_queue.sv]
// sorted list of expired ids, insertion by id, popped from the head
`timescale 1ns / 1ps

module fptb_hit_queue (
	input  logic                          clk,
	input  logic                          arst_n,
	input  fptb_pkg::hq_ctrl_t            ctrl,
	input  logic [fptb_pkg::ID_W-1:0]     ins_id,
	output logic [fptb_pkg::ID_W-1:0]     head_id,
	output logic [fptb_pkg::CNT_W-1:0]    count
);

	import fptb_pkg::*;

	logic [ID_W-1:0]       ids_q [NUM_TIMERS];
	logic [CNT_W-1:0]      cnt_q;
	logic [NUM_TIMERS-1:0] gt;

	// entries strictly above the new id move up; equal ids keep slot order
	always_comb begin
		for (int k = 0; k < NUM_TIMERS; k++) begin
			gt[k] = (CNT_W'(k) < cnt_q) && (ids_q[k] > ins_id);
		end
	end

	for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_ent
		logic shift_in;
		logic place;
		logic [ID_W-1:0] below;

		if (g == 0) begin : g_first
			assign shift_in = 1'b0;
			assign place    = gt[0] || (cnt_q == '0);
		end else begin : g_rest
			assign shift_in = gt[g-1];
			assign place    = !gt[g-1] && (gt[g] || (CNT_W'(g) == cnt_q));
		end

		if (g == NUM_TIMERS - 1) begin : g_top
			assign below = ids_q[g];
		end else begin : g_mid
			assign below = ids_q[g+1];
		end

		always_ff @(posedge clk) begin
			if (ctrl.ins) begin
				if (shift_in) begin
					ids_q[g] <= ids_q[(g == 0) ? 0 : g-1];
				end else if (place) begin
					ids_q[g] <= ins_id;
				end
			end else if (ctrl.pop) begin
				ids_q[g] <= below;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctrl.ins) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end else if (ctrl.pop) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	assign head_id = ids_q[0];
	assign count   = cnt_q;

endmodule

[bench/tb_fractional_period_timer_bank_core.sv]
// testbench for the fractional period timer bank: directed table, then random requests
`timescale 1ns / 1ps

module tb_fractional_period_timer_bank_core;
	import fptb_pkg::*;

	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam int RANDOM_REQUESTS = 480;
	localparam int CALM_REQUESTS   = 60;
	localparam int DRAIN_CYCLES    = 3 * NUM_TIMERS + 16;
	// the slowest tick walks every slot, then sends 16 results, each of which the
	// result side may stall; the limit takes that many times over
	localparam int QUIET_LIMIT     = 4000;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [ID_W-1:0]   id;
		logic              last;
	} timer_result_t;

	typedef struct packed {
		logic [MODE_W-1:0]    mode;
		logic [WHOLE_W-1:0]   whole;
		logic [15:0]          frac;
		logic                 rep;
		logic [ID_W-1:0]      target;
		logic [7:0]           count;
		logic                 typed;
		logic [KIND_W-1:0]    kind;
		logic [ID_W-1:0]      id;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [71:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;

	// expected result typed in the table for the request now offered
	logic              row_typed;
	logic [KIND_W-1:0] row_kind;
	logic [ID_W-1:0]   row_id;

	logic calm;
	int   errors = 0;
	int   quiet_cycles = 0;

	// predicted bank state
	logic                 live      [NUM_TIMERS];
	logic [ID_W-1:0]      slot_tag  [NUM_TIMERS];
	logic [FRAMES_W-1:0]  frames_cnt [NUM_TIMERS];
	logic [WHOLE_W-1:0]   whole_rl  [NUM_TIMERS];
	logic [ACC_W-1:0]     accum     [NUM_TIMERS];
	logic [FRAC_BITS-1:0] frac_rl   [NUM_TIMERS];
	logic                 recur     [NUM_TIMERS];
	logic [ID_W-1:0]      id_ctr;

	timer_result_t step_results[$];
	timer_result_t due_results[$];
	stim_row_t     plan[$];

	fractional_period_timer_bank_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic timer_result_t mk_result(input logic [KIND_W-1:0] kind,
		input logic [ID_W-1:0] id, input logic last);
		timer_result_t r;
		r.kind = kind;
		r.id   = id;
		r.last = last;
		return r;
	endfunction

	// runs one request through the predicted bank, results land in step_results
	function automatic void advance_bank(input logic [MODE_W-1:0] mode,
		input logic [WHOLE_W-1:0] whole, input logic [15:0] frac, input logic rep,
		input logic [ID_W-1:0] target);
		int hits[$];
		int tmp;
		int b;
		bit done;
		logic [WHOLE_W-1:0] w;
		step_results.delete();
		done = 0;
		case (mode)
		MODE_ADD: begin
			w = (whole == '0) ? WHOLE_W'(1) : whole;
			for (int s = 0; s < NUM_TIMERS; s++) begin
				if (!done && !live[s]) begin
					live[s]        = 1'b1;
					slot_tag[s]    = id_ctr;
					frames_cnt[s]  = {1'b0, w};
					whole_rl[s]    = w;
					accum[s]       = {1'b0, frac[FRAC_BITS-1:0]};
					frac_rl[s]     = frac[FRAC_BITS-1:0];
					recur[s]       = rep;
					step_results.insert(step_results.size(),
						mk_result(K_ADDED, id_ctr, 1'b1));
					id_ctr = id_ctr + 1'b1;
					done = 1;
				end
			end
			if (!done)
				step_results.insert(step_results.size(), mk_result(K_FULL, '0, 1'b1));
		end
		MODE_CANCEL: begin
			for (int s = 0; s < NUM_TIMERS; s++) begin
				if (!done && live[s] && slot_tag[s] == target) begin
					live[s] = 1'b0;
					done = 1;
				end
			end
			step_results.insert(step_results.size(),
				mk_result(done ? K_CANCELLED : K_MISS, target, 1'b1));
		end
		MODE_TICK: begin
			for (int s = 0; s < NUM_TIMERS; s++) begin
				if (live[s]) begin
					frames_cnt[s] = frames_cnt[s] - 1'b1;
					if (frames_cnt[s] == '0) begin
						hits.insert(hits.size(), s);
						if (recur[s]) begin
							accum[s] = accum[s] + {1'b0, frac_rl[s]};
							// extra frame only when strictly above one
							if (accum[s] > ONE_FIX) begin
								accum[s] = accum[s] - ONE_FIX;
								frames_cnt[s] = frames_cnt[s] + 1'b1;
							end
							frames_cnt[s] = frames_cnt[s] + {1'b0, whole_rl[s]};
						end else begin
							live[s] = 1'b0;
						end
					end
				end
			end
			// stable insertion sort by id, equal ids stay in slot order
			for (int a = 1; a < hits.size(); a++) begin
				tmp = hits[a];
				b = a;
				while (b > 0 && slot_tag[hits[b-1]] > slot_tag[tmp]) begin
					hits[b] = hits[b-1];
					b--;
				end
				hits[b] = tmp;
			end
			if (hits.size() == 0)
				step_results.insert(step_results.size(), mk_result(K_NONE, '0, 1'b1));
			foreach (hits[h])
				step_results.insert(step_results.size(),
					mk_result(K_EXPIRED, slot_tag[hits[h]], h == hits.size() - 1));
		end
		default: ;
		endcase
	endfunction

	task automatic flag_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
		errors++;
	endtask

	// result check, request prediction and idle count, all at the rising edge
	always @(posedge clk) begin
		timer_result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (due_results.size() == 0) begin
					flag_mismatch("unexpected result id", m_tdata, '0);
				end else begin
					want = due_results.pop_front();
					if (m_tuser != want.kind)
						flag_mismatch("kind", 32'(m_tuser), 32'(want.kind));
					if (m_tdata != want.id)
						flag_mismatch("timer id", m_tdata, want.id);
					if (m_tlast != want.last)
						flag_mismatch("last", 32'(m_tlast), 32'(want.last));
				end
			end
			if (s_tvalid && s_tready) begin
				advance_bank(s_tuser, s_tdata[15:0], s_tdata[31:16], s_tdata[32],
					s_tdata[64:33]);
				if (row_typed)
					due_results.insert(due_results.size(),
						mk_result(row_kind, row_id, 1'b1));
				else
					foreach (step_results[k])
						due_results.insert(due_results.size(), step_results[k]);
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

	// result side stalls in bursts
	initial begin
		int stall_left;
		m_tready = 1'b0;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (calm) begin
				m_tready = 1'b1;
			end else if (stall_left > 0) begin
				m_tready = 1'b0;
				stall_left--;
			end else if ($urandom_range(9) == 0) begin
				m_tready = 1'b0;
				stall_left = $urandom_range(1, 12) - 1;
			end else begin
				m_tready = 1'b1;
			end
		end
	end

	task automatic push_row(input logic [MODE_W-1:0] mode, input logic [15:0] whole,
		input logic [15:0] frac, input logic rep, input logic [31:0] target,
		input int count, input logic typed, input logic [KIND_W-1:0] kind,
		input logic [31:0] id);
		stim_row_t r;
		r.mode   = mode;
		r.whole  = whole;
		r.frac   = frac;
		r.rep    = rep;
		r.target = target;
		r.count  = 8'(count);
		r.typed  = typed;
		r.kind   = kind;
		r.id     = id;
		plan.insert(plan.size(), r);
	endtask

	// called at a falling edge, returns at a falling edge
	task automatic maybe_pause();
		int gap;
		if (!calm && $urandom_range(7) == 0) begin
			s_tvalid = 1'b0;
			gap = $urandom_range(1, 12);
			repeat (gap) @(negedge clk);
		end
	endtask

	// called at a falling edge, returns at the rising edge that takes the request
	task automatic offer(input logic [MODE_W-1:0] mode, input logic [15:0] whole,
		input logic [15:0] frac, input logic rep, input logic [31:0] target,
		input logic typed, input logic [KIND_W-1:0] kind, input logic [31:0] id);
		s_tdata   = {7'b0, target, rep, frac, whole};
		s_tuser   = mode;
		row_typed = typed;
		row_kind  = kind;
		row_id    = id;
		s_tvalid  = 1'b1;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain_pause();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (due_results.size() != 0) @(negedge clk);
	endtask

	initial begin
		stim_row_t row;
		int live_slots[$];
		int r;
		logic [MODE_W-1:0] mode;
		logic [15:0] whole;
		logic [15:0] frac;
		logic rep;
		logic [31:0] target;

		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = MODE_TICK;
		row_typed = 1'b0;
		row_kind = K_ADDED;
		row_id = '0;
		calm = 1'b0;
		id_ctr = '0;
		for (int s = 0; s < NUM_TIMERS; s++) begin
			live[s] = 1'b0;
			slot_tag[s] = '0;
			frames_cnt[s] = '0;
			whole_rl[s] = '0;
			accum[s] = '0;
			frac_rl[s] = '0;
			recur[s] = 1'b0;
		end

		push_row(MODE_TICK, 16'h0000, 16'h0000, 1'b0, 32'h0, 1, 1'b1, K_NONE, 32'h0);
		push_row(MODE_CANCEL, 16'h0000, 16'h0000, 1'b0, 32'hFFFFFFFF, 1, 1'b1, K_MISS,
			32'hFFFFFFFF);
		// zero whole period counts as one frame
		push_row(MODE_ADD, 16'h0000, 16'h0000, 1'b1, 32'h0, 1, 1'b1, K_ADDED, 32'd0);
		push_row(MODE_ADD, 16'hFFFF, 16'hFFFF, 1'b0, 32'h0, 1, 1'b1, K_ADDED, 32'd1);
		push_row(MODE_ADD, 16'h0001, 16'hFFFF, 1'b1, 32'h0, 1, 1'b1, K_ADDED, 32'd2);
		push_row(MODE_ADD, 16'h0002, 16'h8000, 1'b1, 32'h0, 1, 1'b1, K_ADDED, 32'd3);
		// unused mode with every data bit set gives nothing back
		push_row(MODE_UNUSED, 16'hFFFF, 16'hFFFF, 1'b1, 32'hFFFFFFFF, 1, 1'b0, K_ADDED, 0);
		push_row(MODE_TICK, 16'h0000, 16'h0000, 1'b0, 32'h0, 3, 1'b0, K_ADDED, 0);
		push_row(MODE_CANCEL, 16'h0000, 16'h0000, 1'b0, 32'd1, 1, 1'b1, K_CANCELLED, 32'd1);
		push_row(MODE_CANCEL, 16'h0000, 16'h0000, 1'b0, 32'd1, 1, 1'b1, K_MISS, 32'd1);
		// fill the bank, then one more add is turned away
		push_row(MODE_ADD, 16'h0001, 16'h0001, 1'b0, 32'h0, 13, 1'b0, K_ADDED, 0);
		push_row(MODE_ADD, 16'h0005, 16'h0000, 1'b1, 32'h0, 1, 1'b1, K_FULL, 32'd0);
		// many expiries in one tick, sorted by id
		push_row(MODE_TICK, 16'h0000, 16'h0000, 1'b0, 32'h0, 1, 1'b0, K_ADDED, 0);
		push_row(MODE_CANCEL, 16'h0000, 16'h0000, 1'b0, 32'd0, 1, 1'b1, K_CANCELLED, 32'd0);

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (plan[p]) begin
			row = plan[p];
			for (int k = 0; k < row.count; k++) begin
				@(negedge clk);
				maybe_pause();
				offer(row.mode, row.whole, row.frac, row.rep, row.target, row.typed,
					row.kind, row.id);
			end
		end
		drain_pause();

		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			if (n == RANDOM_REQUESTS / 2)
				drain_pause();
			if (n == RANDOM_REQUESTS - CALM_REQUESTS)
				calm = 1'b1;
			@(negedge clk);
			maybe_pause();
			whole  = 16'($urandom_range(0, 65535));
			frac   = 16'($urandom_range(0, 65535));
			rep    = 1'($urandom_range(0, 1));
			target = $urandom();
			r = $urandom_range(99);
			if (r < 40) begin
				mode = MODE_TICK;
			end else if (r < 72) begin
				mode = MODE_ADD;
				r = $urandom_range(99);
				// mostly short periods so timers expire; a few long ones hold slots
				if (r < 8)
					whole = '0;
				else if (r < 85)
					whole = 16'($urandom_range(1, 6));
				else if (r < 95)
					whole = 16'($urandom_range(7, 40));
				r = $urandom_range(19);
				if (r == 0)
					frac = '0;
				else if (r == 1)
					frac = 16'hFFFF;
				else if (r == 2)
					frac = 16'h8000;
			end else if (r < 96) begin
				mode = MODE_CANCEL;
				live_slots.delete();
				for (int s = 0; s < NUM_TIMERS; s++)
					if (live[s])
						live_slots.insert(live_slots.size(), s);
				if (live_slots.size() != 0 && $urandom_range(3) != 0)
					target = slot_tag[live_slots[$urandom_range(0, live_slots.size() - 1)]];
			end else begin
				mode = MODE_UNUSED;
			end
			offer(mode, whole, frac, rep, target, 1'b0, K_ADDED, '0);
		end

		@(negedge clk);
		s_tvalid = 1'b0;
		while (due_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
